// File: hdl/psch_pkg.sv
// Shared types and constants for the preemptive priority scheduler.
// Used by psch_ctrl, psch_dp and preemptive_priority_scheduler; no dependencies.
package psch_pkg;

  // Default number of ready-table slots.
  localparam int unsigned TASK_SLOTS_DEF = 16;

  // Field widths
  localparam int unsigned ID_W    = 8;
  localparam int unsigned BURST_W = 16;
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned TIME_W  = 32;

  // One table entry in RAM: {task id, priority, remaining burst}
  localparam int unsigned ENTRY_W = ID_W + PRIO_W + BURST_W;

  // Opcodes
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_ARRIVE = 1'b1;

  // Controller -> datapath commands
  typedef struct packed {
    logic start;   // latch the input item, clear the scan
    logic step;    // visit one slot
    logic commit;  // update the table and load the result register
  } psch_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic scan_last;  // scan pointer is on the last slot
    logic out_free;   // result register can take a new result
  } psch_sts_t;

endpackage

// File: hdl/psch_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psch_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/psch_ctrl.sv
// Control state machine of the scheduler: accept, scan, drain, commit.
// Depends on psch_pkg.
module psch_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  psch_pkg::psch_sts_t sts,
  output psch_pkg::psch_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r, in_stall_nxt;

  always_comb begin
    state_nxt    = state_r;
    in_stall_nxt = in_stall_r;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start    = 1'b1;
          state_nxt    = ST_SCAN;
          in_stall_nxt = 1'b1;
        end
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last RAM read lands and is compared
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit   = 1'b1;
          state_nxt    = ST_IDLE;
          in_stall_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt    = ST_IDLE;
        in_stall_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= in_stall_nxt;
    end
  end

  assign in_stall = in_stall_r;

endmodule

// File: hdl/psch_dp.sv
// Scheduler datapath: ready table (valid flops + entry RAM), slot scan,
// best/free-slot tracking, tick counter and result register.
// Depends on psch_pkg and psch_ram.
module psch_dp #(
  parameter int unsigned TASK_SLOTS = psch_pkg::TASK_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  psch_pkg::psch_cmd_t          cmd,
  output psch_pkg::psch_sts_t          sts,
  input  logic                         in_opcode,
  input  logic [psch_pkg::ID_W-1:0]    in_task_id,
  input  logic [psch_pkg::BURST_W-1:0] in_burst_length,
  input  logic [psch_pkg::PRIO_W-1:0]  in_priority_req,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_accepted,
  output logic                         out_table_full,
  output logic                         out_ran_valid,
  output logic [psch_pkg::ID_W-1:0]    out_ran_task_id,
  output logic                         out_finished,
  output logic [psch_pkg::TIME_W-1:0]  out_tick_time
);

  localparam int unsigned IDX_W = $clog2(TASK_SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);

  // latched input item
  logic                         op_r;
  logic [psch_pkg::ID_W-1:0]    id_r;
  logic [psch_pkg::BURST_W-1:0] burst_r;
  logic [psch_pkg::PRIO_W-1:0]  prio_r;

  // table
  logic [TASK_SLOTS-1:0] valid_r, valid_nxt;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [psch_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;

  // scan
  logic [IDX_W-1:0] scan_r;
  logic             cmp_go_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic             cmp_slot_r;

  // search results
  logic                         found_r;
  logic [IDX_W-1:0]             best_idx_r;
  logic [psch_pkg::ID_W-1:0]    best_task_r;
  logic [psch_pkg::PRIO_W-1:0]  best_prio_r;
  logic [psch_pkg::BURST_W-1:0] best_rem_r;
  logic                         free_found_r;
  logic [IDX_W-1:0]             free_idx_r;

  logic [psch_pkg::ID_W-1:0]    rd_task;
  logic [psch_pkg::PRIO_W-1:0]  rd_prio;
  logic [psch_pkg::BURST_W-1:0] rd_rem;
  logic [psch_pkg::BURST_W-1:0] rem_dec;
  logic                         done;

  logic [psch_pkg::TIME_W-1:0] tick_r;

  // result register
  logic                        out_valid_r;
  logic                        acc_r, full_r, ran_r, fin_r;
  logic [psch_pkg::ID_W-1:0]   ran_id_r;
  logic [psch_pkg::TIME_W-1:0] time_r;

  logic is_arrive;

  assign is_arrive = (op_r == psch_pkg::OP_ARRIVE);
  assign {rd_task, rd_prio, rd_rem} = ram_rdata;

  // burst never drops below zero; a zero burst finishes on its first tick
  assign rem_dec = (best_rem_r == '0) ? '0 : best_rem_r - 1'b1;
  assign done    = (rem_dec == '0);

  assign sts.scan_last = (scan_r == LAST_IDX);
  assign sts.out_free  = !out_valid_r || !out_stall;

  psch_ram #(
    .WIDTH(psch_pkg::ENTRY_W),
    .DEPTH(TASK_SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.step),
    .raddr(scan_r),
    .rdata(ram_rdata)
  );

  always_comb begin
    valid_nxt = valid_r;
    ram_we    = 1'b0;
    ram_waddr = best_idx_r;
    ram_wdata = {best_task_r, best_prio_r, rem_dec};
    if (cmd.commit) begin
      if (is_arrive) begin
        if (free_found_r) begin
          valid_nxt[free_idx_r] = 1'b1;
          ram_we    = 1'b1;
          ram_waddr = free_idx_r;
          ram_wdata = {id_r, prio_r, burst_r};
        end
      end else if (found_r) begin
        if (done) begin
          valid_nxt[best_idx_r] = 1'b0;
        end else begin
          ram_we = 1'b1;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      scan_r       <= '0;
      cmp_go_r     <= 1'b0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      tick_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      cmp_go_r <= cmd.step;
      if (cmd.start) begin
        scan_r       <= '0;
        found_r      <= 1'b0;
        free_found_r <= 1'b0;
      end else begin
        if (cmd.step) begin
          scan_r <= scan_r + 1'b1;
          if (!free_found_r && !valid_r[scan_r]) begin
            free_found_r <= 1'b1;
          end
        end
        if (cmp_go_r && cmp_slot_r && (!found_r || rd_prio > best_prio_r)) begin
          found_r <= 1'b1;
        end
      end
      if (cmd.commit && !is_arrive) begin
        tick_r <= tick_r + 1'b1;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r    <= in_opcode;
      id_r    <= in_task_id;
      burst_r <= in_burst_length;
      prio_r  <= in_priority_req;
    end
    if (cmd.step) begin
      cmp_idx_r  <= scan_r;
      cmp_slot_r <= valid_r[scan_r];
      if (!free_found_r && !valid_r[scan_r]) begin
        free_idx_r <= scan_r;
      end
    end
    if (!cmd.start && cmp_go_r && cmp_slot_r && (!found_r || rd_prio > best_prio_r)) begin
      best_idx_r  <= cmp_idx_r;
      best_task_r <= rd_task;
      best_prio_r <= rd_prio;
      best_rem_r  <= rd_rem;
    end
    if (cmd.commit) begin
      time_r <= tick_r;
      if (is_arrive) begin
        acc_r    <= free_found_r;
        full_r   <= !free_found_r;
        ran_r    <= 1'b0;
        ran_id_r <= '0;
        fin_r    <= 1'b0;
      end else begin
        acc_r    <= 1'b0;
        full_r   <= 1'b0;
        ran_r    <= found_r;
        ran_id_r <= found_r ? best_task_r : '0;
        fin_r    <= found_r && done;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_accepted    = acc_r;
  assign out_table_full  = full_r;
  assign out_ran_valid   = ran_r;
  assign out_ran_task_id = ran_id_r;
  assign out_finished    = fin_r;
  assign out_tick_time   = time_r;

endmodule

// File: hdl/preemptive_priority_scheduler.sv
// Top level of the tick-driven preemptive priority scheduler.
// Depends on psch_pkg, psch_ctrl, psch_dp (and psch_ram below it).
//
// Usage:
//   Input channel (in_*): one item per transfer. in_opcode = tick runs the
//   highest-priority ready task (ties to the lowest slot) for one tick;
//   in_opcode = arrive stores {task_id, burst_length, priority_req} in the
//   lowest free slot, or reports table_full if none is free.
//   Result channel (out_*): exactly one result per input item, in order.
//   Each item runs a slot scan, which reads one table entry per cycle
//   through the single read port of the entry RAM, then the drain and
//   commit states. in_stall is high from the input transfer until the
//   commit, so a new item is not taken before the last one is through.
//   Stalls: the result register holds while out_stall is high; a new item
//   can be taken meanwhile, but its commit waits until the register frees.
//   Reset (rst_n low, synchronous): all slots empty, tick counter zero,
//   no result pending. Entry RAM contents are not cleared; only slots
//   marked valid are ever used.
module preemptive_priority_scheduler #(
  parameter int unsigned TASK_SLOTS = psch_pkg::TASK_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_opcode,
  input  logic [psch_pkg::ID_W-1:0]    in_task_id,
  input  logic [psch_pkg::BURST_W-1:0] in_burst_length,
  input  logic [psch_pkg::PRIO_W-1:0]  in_priority_req,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_accepted,
  output logic                         out_table_full,
  output logic                         out_ran_valid,
  output logic [psch_pkg::ID_W-1:0]    out_ran_task_id,
  output logic                         out_finished,
  output logic [psch_pkg::TIME_W-1:0]  out_tick_time
);

  psch_pkg::psch_cmd_t cmd;
  psch_pkg::psch_sts_t sts;

  // sequencing: idle -> scan all slots -> drain last read -> commit
  psch_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  // table, search and result register
  psch_dp #(
    .TASK_SLOTS(TASK_SLOTS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_opcode      (in_opcode),
    .in_task_id     (in_task_id),
    .in_burst_length(in_burst_length),
    .in_priority_req(in_priority_req),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_accepted   (out_accepted),
    .out_table_full (out_table_full),
    .out_ran_valid  (out_ran_valid),
    .out_ran_task_id(out_ran_task_id),
    .out_finished   (out_finished),
    .out_tick_time  (out_tick_time)
  );

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for preemptive_priority_scheduler: directed table plus random
// arrive/tick traffic, every result checked against typed rows or a slot-table predictor.
// Depends on psch_pkg and the scheduler RTL only.
module tb_top;

  localparam int unsigned SLOTS          = psch_pkg::TASK_SLOTS_DEF;
  localparam int unsigned ID_W           = psch_pkg::ID_W;
  localparam int unsigned BURST_W        = psch_pkg::BURST_W;
  localparam int unsigned PRIO_W         = psch_pkg::PRIO_W;
  localparam int unsigned TIME_W         = psch_pkg::TIME_W;
  localparam int          RAND_ITEMS     = 1725;
  localparam int          HOLD_AT        = 600;   // random item where the long out_stall starts
  localparam int          DRAIN_AT       = 1100;  // random item where the sender waits for empty
  localparam int          LONG_HOLD      = 400;   // cycles of the long receiver hold-off
  localparam int          WATCHDOG_LIMIT = 5000;  // cycles with no transfer on either side

  // One input item and one result, at the block's widths.
  typedef struct packed {
    logic               op;
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
  } sched_item_t;

  typedef struct packed {
    logic              accepted;
    logic              table_full;
    logic              ran_valid;
    logic [ID_W-1:0]   ran_id;
    logic              finished;
    logic [TIME_W-1:0] tick_time;
  } sched_res_t;

  // Directed row: typed_exp set means res is the hand-written expectation.
  typedef struct {
    sched_item_t it;
    bit          typed_exp;
    sched_res_t  res;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_opcode;
  logic [ID_W-1:0]    in_task_id;
  logic [BURST_W-1:0] in_burst_length;
  logic [PRIO_W-1:0]  in_priority_req;
  logic               out_valid;
  logic               out_stall;
  logic               out_accepted;
  logic               out_table_full;
  logic               out_ran_valid;
  logic [ID_W-1:0]    out_ran_task_id;
  logic               out_finished;
  logic [TIME_W-1:0]  out_tick_time;

  // Predictor state: mirror of the ready table and the tick counter.
  logic               slot_busy [SLOTS];
  logic [BURST_W-1:0] slot_left [SLOTS];
  logic [PRIO_W-1:0]  slot_prio [SLOTS];
  logic [ID_W-1:0]    slot_tid  [SLOTS];
  logic [TIME_W-1:0]  tick_now;

  sched_res_t pending_results[$];  // expected results, oldest first
  dir_row_t   dir_rows[$];
  int         mismatch_count;
  int         quiet_cycles;
  int         burst_left;          // items left in the current sender burst
  bit         long_hold;           // sender asks the receiver for the long hold-off

  preemptive_priority_scheduler #(
    .TASK_SLOTS(SLOTS)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_task_id     (in_task_id),
    .in_burst_length(in_burst_length),
    .in_priority_req(in_priority_req),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_accepted   (out_accepted),
    .out_table_full (out_table_full),
    .out_ran_valid  (out_ran_valid),
    .out_ran_task_id(out_ran_task_id),
    .out_finished   (out_finished),
    .out_tick_time  (out_tick_time)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  function automatic sched_res_t mk_res(input logic acc, input logic full, input logic ran,
                                        input logic [ID_W-1:0] tid, input logic fin,
                                        input logic [TIME_W-1:0] t);
    sched_res_t r;
    r.accepted   = acc;
    r.table_full = full;
    r.ran_valid  = ran;
    r.ran_id     = tid;
    r.finished   = fin;
    r.tick_time  = t;
    return r;
  endfunction

  // Applies one item to the predictor state and returns the result it yields.
  // Arrive: lowest free slot. Tick: highest priority, ties to the lowest slot;
  // a zero burst still occupies its tick and finishes in it.
  function automatic sched_res_t predict_dispatch(input sched_item_t it);
    sched_res_t r;
    int         pick;
    r = '0;
    r.tick_time = tick_now;
    pick = -1;
    if (it.op == psch_pkg::OP_ARRIVE) begin
      for (int s = 0; s < SLOTS; s++)
        if (!slot_busy[s] && pick < 0) pick = s;
      if (pick >= 0) begin
        slot_busy[pick] = 1'b1;
        slot_left[pick] = it.burst;
        slot_prio[pick] = it.prio;
        slot_tid[pick]  = it.id;
        r.accepted = 1'b1;
      end else begin
        r.table_full = 1'b1;
      end
    end else begin
      for (int s = 0; s < SLOTS; s++)
        if (slot_busy[s] && (pick < 0 || slot_prio[s] > slot_prio[pick])) pick = s;
      if (pick >= 0) begin
        r.ran_valid = 1'b1;
        r.ran_id    = slot_tid[pick];
        if (slot_left[pick] != '0) slot_left[pick] = slot_left[pick] - 1'b1;
        if (slot_left[pick] == '0) begin
          slot_busy[pick] = 1'b0;
          r.finished = 1'b1;
        end
      end
      tick_now = tick_now + 1'b1;
    end
    return r;
  endfunction

  task automatic add_row(input logic op, input logic [ID_W-1:0] tid,
                         input logic [BURST_W-1:0] burst, input logic [PRIO_W-1:0] prio,
                         input bit typed_exp, input sched_res_t res);
    dir_row_t row;
    row.it        = '{op: op, id: tid, burst: burst, prio: prio};
    row.typed_exp = typed_exp;
    row.res       = res;
    dir_rows.push_back(row);
  endtask

  // Holds the item on the input port until a transfer, then records the
  // expectation. Entered and left right after a rising edge.
  task automatic offer(input sched_item_t it, input bit typed_exp, input sched_res_t typed_res);
    sched_res_t pred;
    in_valid        <= 1'b1;
    in_opcode       <= it.op;
    in_task_id      <= it.id;
    in_burst_length <= it.burst;
    in_priority_req <= it.prio;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = predict_dispatch(it);
    pending_results.push_back(typed_exp ? typed_res : pred);
  endtask

  // Bursty sender: after a burst of transfers, drop valid for a random gap.
  task automatic sender_gap();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 25)) @(posedge clk);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, fname, want, got);
      mismatch_count++;
    end
  endtask

  // Result side: every transfer is checked against the oldest expectation.
  always @(posedge clk) begin : result_check
    sched_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, expected none actual tick_time %0h",
                 $time, out_tick_time);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("accepted",    32'(want.accepted),   32'(out_accepted));
        check_field("table_full",  32'(want.table_full), 32'(out_table_full));
        check_field("ran_valid",   32'(want.ran_valid),  32'(out_ran_valid));
        check_field("ran_task_id", 32'(want.ran_id),     32'(out_ran_task_id));
        check_field("finished",    32'(want.finished),   32'(out_finished));
        check_field("tick_time",   32'(want.tick_time),  32'(out_tick_time));
      end
    end
  end

  // Watchdog: counts cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver stall generator: stretches of free flow, coin-flip stalls, a fixed
  // pattern and heavy stalling, plus one long hold-off on request from the sender.
  initial begin : rx_stall_gen
    int mode;
    int span;
    int phase;
    bit hold_served;
    phase       = 0;
    hold_served = 1'b0;
    out_stall   = 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold && !hold_served) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_served = 1'b1;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(20, 200);
        while (span > 0 && !(long_hold && !hold_served)) begin
          case (mode)
            0: begin
              out_stall <= 1'b0;
            end
            1: begin
              out_stall <= ($urandom_range(0, 1) == 1);
            end
            2: begin
              out_stall <= ((phase % 5) < 2);
            end
            default: begin
              out_stall <= ($urandom_range(0, 99) < 85);
            end
          endcase
          phase++;
          span--;
          @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    sched_item_t it;
    int          phase_left;
    int          arrive_pct;
    bit          tie_prio;
    bit          longer_bursts;

    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_opcode       = psch_pkg::OP_TICK;
    in_task_id      = '0;
    in_burst_length = '0;
    in_priority_req = '0;
    burst_left      = 0;
    long_hold       = 1'b0;
    phase_left      = 0;
    arrive_pct      = 50;
    tie_prio        = 1'b0;
    longer_bursts   = 1'b0;
    tick_now        = '0;
    for (int s = 0; s < SLOTS; s++) begin
      slot_busy[s] = 1'b0;
      slot_left[s] = '0;
      slot_prio[s] = '0;
      slot_tid[s]  = '0;
    end

    // Directed table. Typed rows: idle tick after reset, zero-burst task,
    // extremes of every field, tie to the lower slot, full-table refusal.
    add_row(psch_pkg::OP_TICK,   8'h00, 16'h0000, 8'h00, 1'b1,
            mk_res(1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 32'd0));
    add_row(psch_pkg::OP_ARRIVE, 8'hA5, 16'h0000, 8'h00, 1'b1,
            mk_res(1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 32'd1));
    add_row(psch_pkg::OP_TICK,   8'hFF, 16'hFFFF, 8'hFF, 1'b1,
            mk_res(1'b0, 1'b0, 1'b1, 8'hA5, 1'b1, 32'd1));
    // long-lived task at the lowest priority sits in slot 0 for the whole run
    add_row(psch_pkg::OP_ARRIVE, 8'hFF, 16'hFFFF, 8'h00, 1'b1,
            mk_res(1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 32'd2));
    add_row(psch_pkg::OP_ARRIVE, 8'h00, 16'h0002, 8'hFF, 1'b1,
            mk_res(1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 32'd2));
    add_row(psch_pkg::OP_ARRIVE, 8'h3C, 16'h0001, 8'hFF, 1'b1,
            mk_res(1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 32'd2));
    add_row(psch_pkg::OP_TICK,   8'h00, 16'h0000, 8'h00, 1'b1,
            mk_res(1'b0, 1'b0, 1'b1, 8'h00, 1'b0, 32'd2));
    add_row(psch_pkg::OP_TICK,   8'h00, 16'h0000, 8'h00, 1'b1,
            mk_res(1'b0, 1'b0, 1'b1, 8'h00, 1'b1, 32'd3));
    // fill the remaining 14 slots; one repeats the id of slot 0
    for (int i = 0; i < 14; i++)
      add_row(psch_pkg::OP_ARRIVE, (i == 3) ? 8'hFF : ID_W'(8'h10 + i),
              BURST_W'(i % 3), PRIO_W'((i * 37) % 256), 1'b0, '0);
    add_row(psch_pkg::OP_ARRIVE, 8'h5A, 16'h0002, 8'h7F, 1'b1,
            mk_res(1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 32'd4));
    add_row(psch_pkg::OP_TICK,   8'h00, 16'h0000, 8'h00, 1'b0, '0);
    add_row(psch_pkg::OP_TICK,   8'h00, 16'h0000, 8'h00, 1'b0, '0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r]) begin
      offer(dir_rows[r].it, dir_rows[r].typed_exp, dir_rows[r].res);
      sender_gap();
    end

    // Random traffic in phases: the arrive share sets how full the table runs,
    // small priority sets force ties, short bursts keep tasks finishing.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (phase_left == 0) begin
        phase_left    = $urandom_range(20, 80);
        case ($urandom_range(0, 3))
          0:       arrive_pct = 15;
          1:       arrive_pct = 40;
          2:       arrive_pct = 55;
          default: arrive_pct = 85;
        endcase
        tie_prio      = ($urandom_range(0, 1) == 1);
        longer_bursts = ($urandom_range(0, 3) == 0);
      end
      phase_left--;

      it.op    = ($urandom_range(0, 99) < arrive_pct) ? psch_pkg::OP_ARRIVE
                                                        : psch_pkg::OP_TICK;
      it.id    = ID_W'($urandom_range(0, 255));
      it.burst = BURST_W'(longer_bursts ? $urandom_range(0, 40) : $urandom_range(0, 4));
      it.prio  = PRIO_W'(tie_prio ? $urandom_range(1, 4) : $urandom_range(0, 255));
      // rare huge burst, parked at the lowest priority so it cannot hog ticks
      if ($urandom_range(0, 199) == 0) begin
        it.burst = BURST_W'($urandom_range(0, 65535));
        it.prio  = '0;
      end

      if (n == HOLD_AT) long_hold = 1'b1;
      if (n == DRAIN_AT) begin
        // sender pauses until every expected result has come back
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        @(posedge clk);
      end

      offer(it, 1'b0, '0);
      sender_gap();
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SLOTS + 20) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
